/* rtl/nct_pkg.sv */
// Shared codes, constants and controller/datapath interface types for the name/count table.
package nct_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int NAME_CHARS_DEF    = 30;

    localparam int NAME_BITS_MAX = 240;
    localparam int COUNT_W       = 31;
    localparam int STATUS_W      = 3;
    localparam int KIND_W        = 2;
    localparam int PORT_IDX_W    = 7;
    localparam int DISTINCT_W    = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_MERGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ_MISS = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rd_issue;
        logic hit;
        logic write_count;
        logic insert;
        logic set_full;
        logic set_empty;
        logic set_read_ok;
        logic set_read_miss;
        logic clear;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              name_empty;
        logic              read_in_range;
        logic              match;
        logic              scan_more;
        logic              pend;
        logic              table_full;
        logic              out_free;
    } stat_t;

endpackage

/* rtl/nct_datapath.sv */
// Datapath of the name/count table: item registers, name and count memories, scan and results.
module nct_datapath #(
    parameter int TABLE_ENTRIES = 128,
    parameter int NAME_CHARS    = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nct_pkg::cmd_t       cmd,
    output nct_pkg::stat_t      stat,
    input  logic [1:0]          kind,
    input  logic [63:0]         name_word0,
    input  logic [63:0]         name_word1,
    input  logic [63:0]         name_word2,
    input  logic [47:0]         name_word3,
    input  logic [30:0]         entry_count,
    input  logic [6:0]          read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [6:0]          entry_index,
    output logic [30:0]         total_count,
    output logic [63:0]         out_word0,
    output logic [63:0]         out_word1,
    output logic [63:0]         out_word2,
    output logic [47:0]         out_word3,
    output logic [7:0]          distinct_total
);
    import nct_pkg::*;

    localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW       = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W    = (CW > PORT_IDX_W) ? CW : PORT_IDX_W;
    localparam int NAME_BITS = NAME_CHARS * 8;
    localparam logic [CW-1:0] FULL_LEVEL = CW'(TABLE_ENTRIES);

    // Keep bytes up to the first zero byte, and never past NAME_CHARS.
    function automatic logic [NAME_BITS-1:0] normalise(input logic [NAME_BITS_MAX-1:0] raw);
        logic [NAME_BITS-1:0] res;
        logic                 alive;
        res   = '0;
        alive = 1'b1;
        for (int p = 0; p < NAME_CHARS; p++) begin
            alive = alive && (raw[p*8 +: 8] != 8'd0);
            res[p*8 +: 8] = alive ? raw[p*8 +: 8] : 8'd0;
        end
        return res;
    endfunction

    logic [NAME_BITS-1:0]  name_mem [TABLE_ENTRIES];
    logic [COUNT_W-1:0]    count_mem [TABLE_ENTRIES];

    logic [KIND_W-1:0]     kind_reg;
    logic [NAME_BITS-1:0]  nm_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [PORT_IDX_W-1:0] ri_reg;

    logic [CW-1:0]         filled_reg;
    logic [CW-1:0]         addr_reg;
    logic                  pend_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [NAME_BITS-1:0]  rd_name_reg;
    logic [COUNT_W-1:0]    rd_count_reg;
    logic [AW-1:0]         upd_idx_reg;

    logic [STATUS_W-1:0]      res_status_reg;
    logic [PORT_IDX_W-1:0]    res_idx_reg;
    logic [COUNT_W-1:0]       res_total_reg;
    logic [NAME_BITS_MAX-1:0] res_words_reg;

    logic [STATUS_W-1:0]      out_status_reg;
    logic [PORT_IDX_W-1:0]    out_idx_reg;
    logic [COUNT_W-1:0]       out_total_reg;
    logic [NAME_BITS_MAX-1:0] out_words_reg;
    logic [DISTINCT_W-1:0]    out_distinct_reg;
    logic                     out_valid_reg;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         ins_addr;
    logic [COUNT_W:0]      sum_wide;
    logic [COUNT_W-1:0]    sum_sat;
    logic                  match;
    logic                  out_free;
    logic                  count_we;
    logic [AW-1:0]         count_wa;
    logic [COUNT_W-1:0]    count_wd;

    assign rd_en    = cmd.scan_step || cmd.rd_issue;
    assign rd_addr  = cmd.scan_step ? addr_reg[AW-1:0] : AW'(ri_reg);
    assign ins_addr = filled_reg[AW-1:0];
    assign match    = pend_reg && (rd_name_reg == nm_reg);
    assign sum_wide = {1'b0, rd_count_reg} + {1'b0, cnt_reg};
    assign sum_sat  = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign count_we = cmd.insert || cmd.write_count;
    assign count_wa = cmd.insert ? ins_addr : upd_idx_reg;
    assign count_wd = cmd.insert ? cnt_reg : res_total_reg;

    always_comb
    begin
        stat.kind          = kind_reg;
        stat.name_empty    = (nm_reg[7:0] == 8'd0);
        stat.read_in_range = (CMP_W'(ri_reg) < CMP_W'(filled_reg));
        stat.match         = match;
        stat.scan_more     = (addr_reg < filled_reg);
        stat.pend          = pend_reg;
        stat.table_full    = (filled_reg == FULL_LEVEL);
        stat.out_free      = out_free;
    end

    // Memories: one write port each, one registered read port shared by scan and read.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            name_mem[ins_addr] <= nm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
        begin
            count_mem[count_wa] <= count_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_name_reg  <= name_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            nm_reg   <= normalise({name_word3, name_word2, name_word1, name_word0});
            cnt_reg  <= entry_count;
            ri_reg   <= read_index;
        end
        if (cmd.hit)
        begin
            upd_idx_reg <= rd_idx_reg;
        end
        if (cmd.hit || cmd.insert || cmd.set_full || cmd.set_empty || cmd.set_read_ok ||
            cmd.set_read_miss || cmd.clear)
        begin
            if (cmd.hit)
            begin
                res_status_reg <= ST_ADDED;
                res_idx_reg    <= PORT_IDX_W'(rd_idx_reg);
                res_total_reg  <= sum_sat;
                res_words_reg  <= '0;
            end
            else if (cmd.insert)
            begin
                res_status_reg <= ST_INSERTED;
                res_idx_reg    <= PORT_IDX_W'(ins_addr);
                res_total_reg  <= cnt_reg;
                res_words_reg  <= '0;
            end
            else if (cmd.set_full)
            begin
                res_status_reg <= ST_DROPPED;
                res_idx_reg    <= '0;
                res_total_reg  <= '0;
                res_words_reg  <= '0;
            end
            else if (cmd.set_empty)
            begin
                res_status_reg <= ST_IGNORED;
                res_idx_reg    <= '0;
                res_total_reg  <= '0;
                res_words_reg  <= '0;
            end
            else if (cmd.set_read_ok)
            begin
                res_status_reg <= ST_READ_OK;
                res_idx_reg    <= ri_reg;
                res_total_reg  <= rd_count_reg;
                res_words_reg  <= NAME_BITS_MAX'(rd_name_reg);
            end
            else if (cmd.set_read_miss)
            begin
                res_status_reg <= ST_READ_MISS;
                res_idx_reg    <= ri_reg;
                res_total_reg  <= '0;
                res_words_reg  <= '0;
            end
            else
            begin
                res_status_reg <= ST_CLEARED;
                res_idx_reg    <= '0;
                res_total_reg  <= '0;
                res_words_reg  <= '0;
            end
        end
        if (cmd.publish)
        begin
            out_status_reg   <= res_status_reg;
            out_idx_reg      <= res_idx_reg;
            out_total_reg    <= res_total_reg;
            out_words_reg    <= res_words_reg;
            out_distinct_reg <= DISTINCT_W'(filled_reg);
        end
    end

    // Control state of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_step;
            if (cmd.scan_start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.clear)
            begin
                filled_reg <= '0;
            end
            else if (cmd.insert)
            begin
                filled_reg <= filled_reg + 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign entry_index    = out_idx_reg;
    assign total_count    = out_total_reg;
    assign out_word0      = out_words_reg[63:0];
    assign out_word1      = out_words_reg[127:64];
    assign out_word2      = out_words_reg[191:128];
    assign out_word3      = out_words_reg[239:192];
    assign distinct_total = out_distinct_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FULL_LEVEL)
        else $error("fill level beyond table size");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> out_free)
        else $error("result published over an untaken result");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (filled_reg < FULL_LEVEL))
        else $error("insert into a full table");

    a_update_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_count |-> $past(match))
        else $error("count write-back without a preceding match");

endmodule

/* rtl/nct_ctrl.sv */
// Controller state machine of the name/count table.
module nct_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  nct_pkg::stat_t stat,
    output nct_pkg::cmd_t  cmd
);
    import nct_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_MERGE:
                    begin
                        if (stat.name_empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    KIND_READ:
                    begin
                        if (stat.read_in_range)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_RDATA;
                        end
                        else
                        begin
                            cmd.set_read_miss = 1'b1;
                            state_next        = S_DONE;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_UPDATE;
                end
                else if (stat.scan_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (!stat.pend)
                begin
                    if (stat.table_full)
                    begin
                        cmd.set_full = 1'b1;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_UPDATE:
            begin
                cmd.write_count = 1'b1;
                state_next      = S_DONE;
            end
            S_RDATA:
            begin
                cmd.set_read_ok = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/name_count_merge_table.sv */
// Top level of the name/count merge table: controller and datapath joined by command and status.
//
// The block holds up to TABLE_ENTRIES distinct names of at most NAME_CHARS characters, each
// with a 31-bit count. A merge transfer searches the filled entries in order, adds its count to
// a matching entry (saturating at 2^31-1), appends the name if there is room, or drops it when
// the table is full; a name whose first character is zero is ignored. A read transfer returns
// one entry and a clear transfer empties the table. Kind 3 is accepted and produces no result.
// Items are handled one at a time. A merge passes through decode, a linear search that reads
// one stored entry per cycle through the single read port of the name memory, a count
// write-back after a hit, and done; a read through decode, read-data and done; a clear, an
// ignored name or a read beyond the filled entries through decode and done. The next transfer
// can be accepted at the edge at which the result can first be taken. The result sits in an
// output register, so the next transfer is taken while an earlier result is still stalled, and
// a new result waits only if the previous one has not been taken. The name and count memories
// are not cleared at reset; only filled entries are ever read, so no clearing pass is needed.
module name_count_merge_table #(
    parameter int TABLE_ENTRIES = nct_pkg::TABLE_ENTRIES_DEF,
    parameter int NAME_CHARS    = nct_pkg::NAME_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [63:0] name_word0,
    input  logic [63:0] name_word1,
    input  logic [63:0] name_word2,
    input  logic [47:0] name_word3,
    input  logic [30:0] entry_count,
    input  logic [6:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [6:0]  entry_index,
    output logic [30:0] total_count,
    output logic [63:0] out_word0,
    output logic [63:0] out_word1,
    output logic [63:0] out_word2,
    output logic [47:0] out_word3,
    output logic [7:0]  distinct_total
);
    import nct_pkg::*;

    // Commands run from the controller into the datapath; status comes back.
    cmd_t  cmd;
    stat_t stat;

    nct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the memories, the scan counter, the fill level and the output register.
    nct_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_CHARS    (NAME_CHARS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .name_word0     (name_word0),
        .name_word1     (name_word1),
        .name_word2     (name_word2),
        .name_word3     (name_word3),
        .entry_count    (entry_count),
        .read_index     (read_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_index    (entry_index),
        .total_count    (total_count),
        .out_word0      (out_word0),
        .out_word1      (out_word1),
        .out_word2      (out_word2),
        .out_word3      (out_word3),
        .distinct_total (distinct_total)
    );

endmodule
